// ===== rtl/hkvs_pkg.sv =====
`timescale 1ns / 1ps
// Package for the hashed key/value store: sizes, status codes, request and
// result types, and the one-at-a-time hash steps. Depends on nothing.
package hkvs_pkg;

  localparam int BUCKETS = 256;
  localparam int WAYS = 4;
  localparam int HASH_W = 32;
  localparam int VAL_W = 32;
  localparam int BKT_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;

  localparam logic [2:0] ST_HIT = 3'd0;
  localparam logic [2:0] ST_MISS = 3'd1;
  localparam logic [2:0] ST_INSERTED = 3'd2;
  localparam logic [2:0] ST_UPDATED = 3'd3;
  localparam logic [2:0] ST_FULL = 3'd4;

  localparam logic MODE_LOOKUP = 1'b0;
  localparam logic MODE_SET = 1'b1;

  typedef struct packed {
    logic mode;
    logic [7:0] key_byte;
    logic has_byte;
    logic last;
    logic signed [VAL_W-1:0] write_value;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic signed [VAL_W-1:0] read_value;
  } rsp_t;

  typedef struct packed {
    logic [WAYS-1:0] vld;
    logic [WAYS-1:0][HASH_W-1:0] key;
    logic [WAYS-1:0][VAL_W-1:0] data;
  } row_t;

  function automatic logic [HASH_W-1:0] mix_byte(input logic [HASH_W-1:0] h,
                                                 input logic [7:0] b);
    logic [HASH_W-1:0] a;
    logic [HASH_W-1:0] c;
    a = h + {{(HASH_W-8){1'b0}}, b};
    c = a + (a << 10);
    return c ^ (c >> 6);
  endfunction

  function automatic logic [HASH_W-1:0] finish_hash(input logic [HASH_W-1:0] h);
    logic [HASH_W-1:0] a;
    logic [HASH_W-1:0] c;
    a = h + (h << 3);
    c = a ^ (a >> 11);
    return c + (c << 15);
  endfunction

endpackage

// ===== rtl/hashed_key_value_store.sv =====
`timescale 1ns / 1ps
// Top level of the hashed key/value store: hash unit, bucket memory and
// output register. Depends on hkvs_pkg.
//
// Usage: a key arrives as a sequence of input requests, one byte each, on
// in_valid/in_stall/in_data. A request with has_byte set folds its byte into
// the running hash; the request with last set also carries the mode (lookup
// or set) and the value to store. Only a last request produces a result on
// out_valid/out_stall/out_data: status and read value.
// Timing: a request that is not last only updates the running hash. A last
// request steps through accept, hash finalize, bucket memory read, then
// compare and write back; its result is registered and visible the cycle
// after the compare. The single-port bucket memory and the read-modify-write
// of one bucket row per key set this sequence.
// Reset clears the running hash, the per-bucket valid flags (so the table
// reads empty at once, with no clearing pass) and the output valid flag.
// While the receiver stalls, the result holds and the block keeps taking key
// bytes; the next last request waits in the compare step until the output
// register is free.
module hashed_key_value_store (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  hkvs_pkg::req_t in_data,
  output logic out_valid,
  input  logic out_stall,
  output hkvs_pkg::rsp_t out_data
);
  import hkvs_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_FIN = 2'd1;
  localparam logic [1:0] S_RD = 2'd2;
  localparam logic [1:0] S_CMP = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic [HASH_W-1:0] hash_r, hash_nxt;
  logic [HASH_W-1:0] key_r;
  logic mode_r;
  logic [VAL_W-1:0] wval_r;
  logic [BUCKETS-1:0] row_vld_r;
  logic out_valid_r;
  rsp_t out_data_r;
  row_t mem [BUCKETS];
  row_t rd_row_r;
  row_t wr_row;
  logic [BKT_W-1:0] bkt;
  logic [WAYS-1:0] way_vld;
  logic match_found, free_found;
  logic [WAY_W-1:0] match_idx, free_idx;
  logic cmp_go, do_write;
  rsp_t rsp;
  logic in_take;

  assign in_take = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign bkt = BKT_W'(key_r % BUCKETS);
  assign cmp_go = (state_r == S_CMP) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    hash_nxt = hash_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_take) begin
          if (in_data.has_byte) begin
            hash_nxt = mix_byte(hash_r, in_data.key_byte);
          end
          if (in_data.last) begin
            state_nxt = S_FIN;
          end
        end
      end
      S_FIN: begin
        hash_nxt = '0;
        state_nxt = S_RD;
      end
      S_RD: begin
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (cmp_go) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      hash_r <= '0;
    end else begin
      state_r <= state_nxt;
      hash_r <= hash_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take && in_data.last) begin
      mode_r <= in_data.mode;
      wval_r <= in_data.write_value;
    end
    if (state_r == S_FIN) begin
      key_r <= finish_hash(hash_r);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_RD) begin
      rd_row_r <= mem[bkt];
    end
    if (do_write) begin
      mem[bkt] <= wr_row;
    end
  end

  always_comb begin
    way_vld = row_vld_r[bkt] ? rd_row_r.vld : '0;
    match_found = 1'b0;
    free_found = 1'b0;
    match_idx = '0;
    free_idx = '0;
    for (int i = 0; i < WAYS; i++) begin
      if (way_vld[i]) begin
        if (!match_found && rd_row_r.key[i] == key_r) begin
          match_found = 1'b1;
          match_idx = WAY_W'(i);
        end
      end else if (!free_found) begin
        free_found = 1'b1;
        free_idx = WAY_W'(i);
      end
    end
  end

  always_comb begin
    wr_row = rd_row_r;
    wr_row.vld = way_vld;
    do_write = 1'b0;
    rsp.status = ST_MISS;
    rsp.read_value = '0;
    if (mode_r == MODE_LOOKUP) begin
      if (match_found) begin
        rsp.status = ST_HIT;
        rsp.read_value = rd_row_r.data[match_idx];
      end
    end else begin
      if (match_found) begin
        rsp.status = ST_UPDATED;
        wr_row.data[match_idx] = wval_r;
        do_write = cmp_go;
      end else if (free_found) begin
        rsp.status = ST_INSERTED;
        wr_row.vld[free_idx] = 1'b1;
        wr_row.key[free_idx] = key_r;
        wr_row.data[free_idx] = wval_r;
        do_write = cmp_go;
      end else begin
        rsp.status = ST_FULL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
    end else if (do_write) begin
      row_vld_r[bkt] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmp_go) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmp_go) begin
      out_data_r <= rsp;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

  a_rd_then_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RD |=> state_r == S_CMP)
    else $error("bucket read not followed by compare");

  a_result_from_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == S_CMP))
    else $error("result appeared without a compare step");

  a_hash_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FIN |=> hash_r == '0)
    else $error("running hash not cleared after key");

  a_row_marked: assert property (@(posedge clk) disable iff (!rst_n)
    do_write |=> row_vld_r[$past(bkt)])
    else $error("written bucket not marked valid");

  a_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_HIT |-> out_data.read_value == '0)
    else $error("read value nonzero without a hit");

endmodule
